[src/lru_key_value_cache_core_assert.svh]
// assertion macros shared by the cache rtl
`ifndef LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH

// expression holds at every clock edge out of reset
`define LKVC_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// expression holds in the cycle after the trigger
`define LKVC_ASSERT_NEXT(name, trig, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) else $error(msg);

`endif

[src/lkvc_pkg.sv]
// shared types and constants for the lru key-value cache
package lkvc_pkg;

  localparam int FIELD_BITS = 16;
  localparam int LIMIT_BITS = 5;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic                  fire;
    logic                  put;
    logic [FIELD_BITS-1:0] key;
    logic [FIELD_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [FIELD_BITS-1:0] read_value;
    logic                  evicted;
    logic [FIELD_BITS-1:0] evicted_key;
  } res_t;

endpackage

[src/lru_key_value_cache_core.sv]
// lru key-value cache top level: stream handshake, input and result registers
//
//  channel | group               | contents
//  --------+---------------------+--------------------------------------------
//  in      | s_tvalid/tready     | tuser: command; tdata: key, value
//  out     | m_tvalid/tready     | tuser: hit, evicted; tdata: read_value, evicted_key
//  config  | cfg_we, cfg_wdata   | active_entries
//
//  one item per cycle unless m_tready stalls; items pass input, then result register
//  lookup, rank update and replacement all happen as the item leaves the input register
//  reset clears valid marks, ranks and count at once; no clearing pass
//  a stalled result holds its register and a full input register; the input side
//  stays ready while the input register is empty or the result register can drain
module lru_key_value_cache_core #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 16,
  parameter int VALUE_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [31:0]                     s_tdata,   // key, value
  input  logic                            s_tuser,   // command
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,   // read_value, evicted_key
  output logic [1:0]                      m_tuser,   // hit, evicted
  input  logic                            cfg_we,
  input  logic [lkvc_pkg::LIMIT_BITS-1:0] cfg_wdata
);
  import lkvc_pkg::*;

  `include "lru_key_value_cache_core_assert.svh"

  logic                  in_v;
  logic                  in_put;
  logic [FIELD_BITS-1:0] in_key;
  logic [FIELD_BITS-1:0] in_value;
  logic                  out_v;
  res_t                  out_res;
  logic [LIMIT_BITS-1:0] active_entries;
  logic                  advance;
  req_t                  req;
  res_t                  res;

  assign advance  = !out_v || m_tready;
  assign s_tready = !in_v || advance;

  always_comb begin
    req.fire  = in_v && advance;
    req.put   = (in_put == CMD_PUT);
    req.key   = in_key;
    req.value = in_value;
  end

  lkvc_table #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_table (
    .clk  (clk),
    .rst  (rst),
    .limit(active_entries),
    .req  (req),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v           <= 1'b0;
      out_v          <= 1'b0;
      active_entries <= LIMIT_RESET;
    end else begin
      if (s_tready) begin
        in_v <= s_tvalid;
      end
      if (advance) begin
        out_v <= in_v;
      end
      if (cfg_we) begin
        active_entries <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_put   <= s_tuser;
      in_key   <= s_tdata[15:0];
      in_value <= s_tdata[31:16];
    end
    if (req.fire) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {out_res.evicted_key, out_res.read_value};
  assign m_tuser  = {out_res.evicted, out_res.hit};

  `LKVC_ASSERT_NEXT(a_item_reaches_result, in_v && advance, out_v, "item lost")
  `LKVC_ASSERT_ALWAYS(a_no_evict_on_hit, !(m_tvalid && m_tuser[1] && m_tuser[0]), "evict on hit")
  `LKVC_ASSERT_NEXT(a_ready_after_drain, out_v && m_tready && !in_v, s_tready, "input stuck")

endmodule

[src/lkvc_table.sv]
// entry table with parallel key match, recency ranks and replacement
module lkvc_table #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 16,
  parameter int VALUE_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [lkvc_pkg::LIMIT_BITS-1:0] limit,
  input  lkvc_pkg::req_t                  req,
  output lkvc_pkg::res_t                  res
);
  import lkvc_pkg::*;

  `include "lru_key_value_cache_core_assert.svh"

  localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int LW = ((CW > LIMIT_BITS) ? CW : LIMIT_BITS) + 1;

  logic [KEY_BITS-1:0]    entry_key   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0]  entry_value [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] entry_valid;
  logic [RW-1:0]          entry_rank  [MAX_ENTRIES];
  logic [CW-1:0]          count;

  logic [KEY_BITS-1:0]    key_in;
  logic [VALUE_BITS-1:0]  value_in;
  logic [MAX_ENTRIES-1:0] match;
  logic [MAX_ENTRIES-1:0] lru_oh;
  logic [MAX_ENTRIES-1:0] free_oh;
  logic [MAX_ENTRIES-1:0] slot_oh;
  logic [RW-1:0]          last_rank;
  logic [RW-1:0]          found_rank;
  logic [VALUE_BITS-1:0]  found_value;
  logic [KEY_BITS-1:0]    lru_key;
  logic [LW-1:0]          lim_req;
  logic [LW-1:0]          lim_max;
  logic [LW-1:0]          lim_eff;
  logic                   hit;
  logic                   full;
  logic                   evict;
  logic                   insert;

  assign key_in    = KEY_BITS'(req.key);
  assign value_in  = VALUE_BITS'(req.value);
  // ranks of valid entries are always 0 .. count-1, so the lru entry has rank count-1
  assign last_rank = RW'(count - CW'(1));

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i]  = entry_valid[i] && (entry_key[i] == key_in);
      lru_oh[i] = entry_valid[i] && (entry_rank[i] == last_rank);
    end
  end

  // lowest free entry
  assign free_oh = ~entry_valid & (entry_valid + MAX_ENTRIES'(1));

  always_comb begin
    found_value = '0;
    found_rank  = '0;
    lru_key     = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match[i]) begin
        found_value = found_value | entry_value[i];
        found_rank  = found_rank | entry_rank[i];
      end
      if (lru_oh[i]) begin
        lru_key = lru_key | entry_key[i];
      end
    end
  end

  assign lim_req = LW'(limit);
  assign lim_max = LW'(MAX_ENTRIES);

  always_comb begin
    priority if (lim_req == '0) begin
      lim_eff = LW'(1);
    end else if (lim_req > lim_max) begin
      lim_eff = lim_max;
    end else begin
      lim_eff = lim_req;
    end
  end

  assign full    = LW'(count) >= lim_eff;
  assign hit     = |match;
  assign evict   = req.put && !hit && full && (count != '0);
  assign slot_oh = evict ? lru_oh : free_oh;
  assign insert  = req.put && !hit && (|slot_oh);

  always_comb begin
    res.hit         = hit;
    res.read_value  = (!req.put && hit) ? FIELD_BITS'(found_value) : '0;
    res.evicted     = evict;
    res.evicted_key = evict ? FIELD_BITS'(lru_key) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      count       <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        entry_rank[i] <= '0;
      end
    end else if (req.fire) begin
      if (hit) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (match[i]) begin
            entry_rank[i] <= '0;
          end else if (entry_valid[i] && (entry_rank[i] < found_rank)) begin
            entry_rank[i] <= entry_rank[i] + RW'(1);
          end
        end
      end else if (insert) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (slot_oh[i]) begin
            entry_rank[i]  <= '0;
            entry_valid[i] <= 1'b1;
          end else if (entry_valid[i]) begin
            entry_rank[i] <= entry_rank[i] + RW'(1);
          end
        end
        if (!evict) begin
          count <= count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.fire) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if ((hit && req.put && match[i]) || (insert && slot_oh[i])) begin
          entry_value[i] <= value_in;
        end
        if (insert && slot_oh[i]) begin
          entry_key[i] <= key_in;
        end
      end
    end
  end

  `LKVC_ASSERT_ALWAYS(a_count_tracks_valid, $countones(entry_valid) == count, "count out of step")
  `LKVC_ASSERT_ALWAYS(a_key_unique, $onehot0(match), "key stored twice")
  `LKVC_ASSERT_ALWAYS(a_lru_single, (count == '0) ? (lru_oh == '0) : $onehot(lru_oh), "ranks broken")

endmodule

[verif/lru_key_value_cache_core_tb.sv]
`timescale 1ns / 1ps
// self-checking stream testbench for the lru key-value cache: directed rows, then random traffic
module lru_key_value_cache_core_tb;
  import lkvc_pkg::*;

  localparam int SLOTS       = 16;
  localparam int HOLD_CYCLES = 250;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SUB_ITEMS   = 66;
  localparam res_t NO_HIT    = '0;

  typedef enum logic { ROW_ITEM, ROW_LIMIT } row_kind_t;

  typedef struct {
    row_kind_t       kind;
    logic            cmd;
    logic [15:0]     key;
    logic [15:0]     value;
    bit              typed;
    res_t            want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata = '0;   // key, value
  logic                  s_tuser = 1'b0; // command
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;        // read_value, evicted_key
  logic [1:0]            m_tuser;        // hit, evicted
  logic                  cfg_we = 1'b0;
  logic [LIMIT_BITS-1:0] cfg_wdata = '0;

  logic [15:0]           shadow_key [SLOTS];
  logic [15:0]           shadow_val [SLOTS];
  bit                    shadow_valid [SLOTS];
  int                    shadow_rank [SLOTS];
  logic [LIMIT_BITS-1:0] shadow_limit = LIMIT_RESET;

  res_t pending_results [$];
  int   mismatches = 0;
  int   cycle_count = 0;
  int   src_idle_pct = 0;
  int   snk_idle_pct = 0;
  int   holds_asked = 0;
  int   holds_done = 0;
  int   hold_left = 0;

  row_t script [24] = '{
    '{ROW_ITEM,  CMD_GET, 16'h0000, 16'h0000, 1'b1, NO_HIT},
    '{ROW_ITEM,  CMD_GET, 16'hFFFF, 16'hFFFF, 1'b1, NO_HIT},
    '{ROW_ITEM,  CMD_PUT, 16'hFFFF, 16'hFFFF, 1'b1, NO_HIT},
    '{ROW_ITEM,  CMD_GET, 16'hFFFF, 16'h0000, 1'b1, '{1'b1, 16'hFFFF, 1'b0, 16'h0000}},
    '{ROW_ITEM,  CMD_PUT, 16'hFFFF, 16'h0000, 1'b1, '{1'b1, 16'h0000, 1'b0, 16'h0000}},
    '{ROW_ITEM,  CMD_GET, 16'hFFFF, 16'h1234, 1'b1, '{1'b1, 16'h0000, 1'b0, 16'h0000}},
    '{ROW_ITEM,  CMD_PUT, 16'h0000, 16'h5A5A, 1'b1, NO_HIT},
    '{ROW_ITEM,  CMD_PUT, 16'h1234, 16'hA5A5, 1'b1, NO_HIT},
    '{ROW_ITEM,  CMD_GET, 16'h0000, 16'hFFFF, 1'b1, '{1'b1, 16'h5A5A, 1'b0, 16'h0000}},
    '{ROW_LIMIT, CMD_GET, 16'h0000, 16'd2,    1'b0, NO_HIT},
    '{ROW_ITEM,  CMD_PUT, 16'h8000, 16'h0001, 1'b1, '{1'b0, 16'h0000, 1'b1, 16'hFFFF}},
    '{ROW_ITEM,  CMD_PUT, 16'h0001, 16'h8000, 1'b1, '{1'b0, 16'h0000, 1'b1, 16'h1234}},
    '{ROW_ITEM,  CMD_GET, 16'hFFFF, 16'h0000, 1'b1, NO_HIT},
    '{ROW_ITEM,  CMD_GET, 16'h8000, 16'h0000, 1'b0, NO_HIT},
    '{ROW_LIMIT, CMD_GET, 16'h0000, 16'd0,    1'b0, NO_HIT},
    '{ROW_ITEM,  CMD_PUT, 16'h7FFF, 16'h8000, 1'b1, '{1'b0, 16'h0000, 1'b1, 16'h0000}},
    '{ROW_ITEM,  CMD_PUT, 16'h00FF, 16'hFF00, 1'b0, NO_HIT},
    '{ROW_ITEM,  CMD_PUT, 16'hFF00, 16'h00FF, 1'b0, NO_HIT},
    '{ROW_ITEM,  CMD_GET, 16'h7FFF, 16'h0000, 1'b0, NO_HIT},
    '{ROW_ITEM,  CMD_PUT, 16'hFF00, 16'h1111, 1'b0, NO_HIT},
    '{ROW_LIMIT, CMD_GET, 16'h0000, 16'd31,   1'b0, NO_HIT},
    '{ROW_ITEM,  CMD_PUT, 16'hAAAA, 16'h5555, 1'b0, NO_HIT},
    '{ROW_ITEM,  CMD_PUT, 16'h5555, 16'hAAAA, 1'b0, NO_HIT},
    '{ROW_ITEM,  CMD_GET, 16'hAAAA, 16'h0000, 1'b0, NO_HIT}
  };

  lru_key_value_cache_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic int limit_in_force(logic [LIMIT_BITS-1:0] setting);
    if (setting == 0) return 1;
    if (setting > SLOTS) return SLOTS;
    return int'(setting);
  endfunction

  function automatic res_t cache_access(logic put, logic [15:0] k, logic [15:0] v);
    res_t r;
    int   found;
    int   free_slot;
    int   oldest;
    int   count;
    int   slot;
    r = '0;
    found = -1;
    free_slot = -1;
    oldest = -1;
    count = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_valid[i]) begin
        count++;
        if (shadow_key[i] == k) found = i;
        if (oldest < 0 || shadow_rank[i] > shadow_rank[oldest]) oldest = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      if (put == CMD_PUT) shadow_val[found] = v;
      else r.read_value = shadow_val[found];
      for (int i = 0; i < SLOTS; i++)
        if (shadow_valid[i] && i != found && shadow_rank[i] < shadow_rank[found])
          shadow_rank[i]++;
      shadow_rank[found] = 0;
    end else if (put == CMD_PUT) begin
      if (count >= limit_in_force(shadow_limit) && oldest >= 0) begin
        r.evicted = 1'b1;
        r.evicted_key = shadow_key[oldest];
        shadow_valid[oldest] = 1'b0;
        slot = oldest;
      end else begin
        slot = free_slot;
      end
      if (slot >= 0) begin
        for (int i = 0; i < SLOTS; i++)
          if (shadow_valid[i]) shadow_rank[i]++;
        shadow_key[slot] = k;
        shadow_val[slot] = v;
        shadow_valid[slot] = 1'b1;
        shadow_rank[slot] = 0;
      end
    end
    return r;
  endfunction

  task automatic send_item(input logic cmd, input logic [15:0] k, input logic [15:0] v,
                           input bit typed, input res_t typed_res);
    res_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {v, k};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = cache_access(cmd, k, v);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // sender pauses here until every result is back, then the limit is written
  task automatic write_limit(input logic [LIMIT_BITS-1:0] setting);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= setting;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_limit = setting;
  endtask

  task automatic run_random(input int n, input logic [LIMIT_BITS-1:0] setting,
                            input bit hold);
    logic [15:0] key_pool [24];
    int          pool_n;
    logic        cmd;
    logic [15:0] k;
    write_limit(setting);
    // long receiver hold-off while the sender keeps offering items
    if (hold) holds_asked <= holds_asked + 1;
    pool_n = limit_in_force(setting) + $urandom_range(1, 6);
    for (int i = 0; i < pool_n; i++) key_pool[i] = 16'($urandom_range(16'hFFFF));
    for (int i = 0; i < n; i++) begin
      cmd = ($urandom_range(99) < 55) ? CMD_PUT : CMD_GET;
      if ($urandom_range(99) < 75) k = key_pool[$urandom_range(pool_n - 1)];
      else k = 16'($urandom_range(16'hFFFF));
      send_item(cmd, k, 16'($urandom_range(16'hFFFF)), 1'b0, NO_HIT);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_done + 1;
      hold_left  <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no expectation: tdata %h tuser %b", m_tdata, m_tuser);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser[0] !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, m_tuser[0]);
          mismatches++;
        end
        if (m_tdata[15:0] !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, m_tdata[15:0]);
          mismatches++;
        end
        if (m_tuser[1] !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, m_tuser[1]);
          mismatches++;
        end
        if (m_tdata[31:16] !== want.evicted_key) begin
          $error("evicted_key: expected %h, got %h", want.evicted_key, m_tdata[31:16]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [LIMIT_BITS-1:0] phase_limits [12];
    phase_limits = '{5'd16, 5'd0, 5'd31, 5'd3, 5'd1, 5'd17, 5'd5, 5'd16, 5'd2, 5'd4, 5'd0, 5'd0};
    for (int i = 0; i < SLOTS; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_rank[i]  = 0;
      shadow_key[i]   = '0;
      shadow_val[i]   = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    src_idle_pct <= 24;
    snk_idle_pct <= 75;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_LIMIT)
        write_limit(script[i].value[LIMIT_BITS-1:0]);
      else
        send_item(script[i].cmd, script[i].key, script[i].value, script[i].typed,
                  script[i].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct <= (ph == 0) ? 24 : (ph == 1) ? 75 : 0;
      snk_idle_pct <= (ph == 0) ? 75 : (ph == 1) ? 24 : 0;
      for (int sub = 0; sub < 4; sub++) begin
        if (ph * 4 + sub >= 10) phase_limits[ph * 4 + sub] = LIMIT_BITS'($urandom_range(31));
        run_random(SUB_ITEMS, phase_limits[ph * 4 + sub], (ph == 2) && (sub == 1));
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[lru_key_value_cache_core.f]
+incdir+src
src/lkvc_pkg.sv
src/lkvc_table.sv
src/lru_key_value_cache_core.sv
verif/lru_key_value_cache_core_tb.sv
